### hw/rtl/linear_probe_hash_map_assert.svh
// Assertion macros used by the checker file of the hash map.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define LPHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hash map check failed");

// Next-cycle implication, inactive while reset is asserted.
`define LPHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hash map check failed");

// Next-cycle implication that is also checked around reset.
`define LPHM_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hash map reset check failed");

`endif

### hw/rtl/lphm_pkg.sv
// Shared constants, types and the home slot hash of the hash map.
// Depends on nothing; imported by the probe engine, the top level and the checker.
package lphm_pkg;

    // Table size; must be a power of two.
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int ENTRY_W = 11;

    localparam logic [63:0] HASH_MULT = 64'd2654435761;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SET    = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic             occ;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_slot            wr_data;
    } t_ram_req;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   read_value;
        logic               status;
        logic [ENTRY_W-1:0] entry_count;
    } t_result;

    // Only the low index bits of key * HASH_MULT mod 2^64 are needed, and those
    // depend only on the low index bits of both factors.
    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [IDX_W-1:0] prod;
        prod = key[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
        return prod;
    endfunction

endpackage

### hw/rtl/lphm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lphm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/lphm_probe.sv
// Probe engine: clearing pass, home slot hash, linear probe walk and update.
// Depends on lphm_pkg; drives the slot RAM through a t_ram_req bundle.
module lphm_probe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [lphm_pkg::KEY_W-1:0]        i_key,
    input  logic [lphm_pkg::VAL_W-1:0]        i_new_value,
    output lphm_pkg::t_ram_req                o_ram,
    input  lphm_pkg::t_slot                   i_rd_data,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output lphm_pkg::t_result                 o_res
);

    import lphm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state           r_state,  n_state;
    logic [IDX_W-1:0] r_clr,    n_clr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_op,     n_op;
    logic [KEY_W-1:0] r_key,    n_key;
    logic [VAL_W-1:0] r_val,    n_val;
    logic [IDX_W-1:0] r_addr,   n_addr;
    logic [IDX_W-1:0] r_probes, n_probes;
    t_result          r_res,    n_res;

    logic slot_hit;
    logic slot_free;
    logic probe_last;

    assign slot_free  = !i_rd_data.occ;
    assign slot_hit   = i_rd_data.occ && (i_rd_data.key == r_key);
    assign probe_last = (r_probes == IDX_W'(CAPACITY - 1));

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_count  = r_count;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_addr   = r_addr;
        n_probes = r_probes;
        n_res    = r_res;
        o_ram    = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_clr;
                n_clr         = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_key    = i_key;
                    n_val    = i_new_value;
                    n_addr   = home_slot(i_key);
                    n_probes = '0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                o_ram.rd_en   = 1'b1;
                o_ram.rd_addr = r_addr;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (slot_hit || slot_free || probe_last) begin
                    n_state          = S_OUT;
                    n_res.found      = slot_hit;
                    n_res.status     = ST_OK;
                    n_res.read_value = '0;
                    if (r_op == OP_LOOKUP) begin
                        if (slot_hit) begin
                            n_res.read_value = i_rd_data.value;
                        end
                    end else if (slot_hit || slot_free) begin
                        o_ram.wr_en         = 1'b1;
                        o_ram.wr_addr       = r_addr;
                        o_ram.wr_data.occ   = 1'b1;
                        o_ram.wr_data.key   = r_key;
                        o_ram.wr_data.value = r_val;
                        n_res.read_value    = r_val;
                        if (!slot_hit) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_res.status = ST_FULL;
                    end
                    n_res.entry_count = ENTRY_W'(n_count);
                end else begin
                    // Keep walking: the next slot is read while this one is compared.
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_addr + IDX_W'(1);
                    n_addr        = r_addr + IDX_W'(1);
                    n_probes      = r_probes + IDX_W'(1);
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_addr   <= n_addr;
        r_probes <= n_probes;
        r_res    <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

endmodule

### hw/rtl/linear_probe_hash_map.sv
// Linear probing hash map, 1024 slots of 64-bit key and 64-bit value.
// Slots probed per item: 1..1024. The probe sequencer takes one item at a time,
// with a single RAM read per probed slot; a new input beat is accepted only after
// the last result has left the engine for the output register.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 1024 slots
// with input ready low, then the map is empty and the entry count is zero.
module linear_probe_hash_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic signed [lphm_pkg::KEY_W-1:0]    i_key,
    input  logic signed [lphm_pkg::VAL_W-1:0]    i_new_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_found,
    output logic signed [lphm_pkg::VAL_W-1:0]    o_read_value,
    output logic                                 o_status,
    output logic        [lphm_pkg::ENTRY_W-1:0]  o_entry_count
);

    import lphm_pkg::*;

    // Bundles between the probe engine and the slot RAM.
    t_ram_req          ram_req;
    logic [SLOT_W-1:0] rd_word;
    t_slot             rd_slot;

    // Result handoff from the probe engine into the output register.
    logic    res_valid;
    logic    res_ready;
    t_result res;

    // Output register; only its valid bit needs a reset.
    logic    r_out_valid;
    t_result r_out;

    // Each slot word carries its occupied mark next to the key and value, so
    // a single read tells the probe whether the slot is free, a hit, or taken
    // by another key. The clearing pass only has to zero the marks.
    lphm_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_word)
    );

    assign rd_slot = t_slot'(rd_word);

    // The probe engine hashes the key to its home slot, then reads one slot per
    // cycle until it meets the key, a free slot, or has seen every slot. A set
    // is written back in the cycle the walk ends; the next item cannot issue a
    // read before that write lands, so no forwarding path is needed.
    lphm_probe u_probe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .o_ram       (ram_req),
        .i_rd_data   (rd_slot),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The output register decouples the two sides: a finished result beat can
    // sit here while the engine already accepts and walks the next item.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out.found;
    assign o_read_value  = $signed(r_out.read_value);
    assign o_status      = r_out.status;
    assign o_entry_count = r_out.entry_count;

endmodule

### hw/rtl/lphm_checker.sv
// Port-level checks of the hash map and the bind that attaches them.
// Depends on lphm_pkg and linear_probe_hash_map_assert.svh.
`include "linear_probe_hash_map_assert.svh"

module lphm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_found,
    input logic signed [lphm_pkg::VAL_W-1:0]    o_read_value,
    input logic                                 o_status,
    input logic        [lphm_pkg::ENTRY_W-1:0]  o_entry_count
);

    import lphm_pkg::*;

    // A refused set reports neither a hit nor a value.
    `LPHM_ASSERT_NOW(a_full_is_miss, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL), !o_found && (o_read_value == '0))

    // One item is walked at a time: an accepted beat drops ready.
    `LPHM_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A stalled result beat holds.
    `LPHM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_read_value) && $stable(o_entry_count))

    // Reset starts the clearing pass with nothing accepted or shown.
    `LPHM_ASSERT_RESET(a_reset_clear, i_clk, !i_rst_n, !o_in_ready && !o_out_valid)

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_found       (o_found),
    .o_read_value  (o_read_value),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
